[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/ssrpg_pkg.sv]
package ssrpg_pkg;

  // Speed format
  localparam int SPEED_FRAC_BITS = 8;
  localparam int SPEED_W         = 27;
  localparam int LIMIT_W         = 26;

  // Timer settings
  localparam int RELOAD_W = 16;
  localparam int CMP_W    = 15;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'hFFFF;
  localparam logic [RELOAD_W-1:0] RELOAD_MIN = 16'd4;

  // Divider numerator: timer clock in speed units
  localparam longint TIMER_HZ  = 1000000;
  localparam longint DIV_NUM   = TIMER_HZ << SPEED_FRAC_BITS;
  localparam int     DIV_NUM_W = $clog2(DIV_NUM + 1);
  localparam int     CNT_W     = $clog2(DIV_NUM_W);
  localparam logic [DIV_NUM_W-1:0] DIV_NUM_BITS = DIV_NUM[DIV_NUM_W-1:0];

  // Quotient saturation bounds (reload = quotient - 1)
  localparam logic [DIV_NUM_W-1:0] Q_LOW  = DIV_NUM_W'(longint'(RELOAD_MIN) + 1);
  localparam logic [DIV_NUM_W-1:0] Q_HIGH = DIV_NUM_W'(longint'(RELOAD_MAX) + 1);

  // Stop threshold: 100*|s| < 2^F  <=>  |s| < ceil(2^F / 100)
  localparam longint STOP_MAG_I = ((longint'(1) << SPEED_FRAC_BITS) + 99) / 100;
  localparam logic [SPEED_W-1:0] STOP_MAG = STOP_MAG_I[SPEED_W-1:0];

  // Request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_STOP = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd1;

endpackage

[rtl/core/stepper_slew_rate_period_gen.sv]
// A stop request goes from acceptance straight to the result step; a speed command passes
// through clamp, slew, magnitude, a restoring divider of one quotient bit per cycle and
// saturation, or skips the divider and saturation when it stops.
// One transaction at a time; an unclaimed result holds the sequencer in its last step.
// Reset (rst_n low, synchronous): limits 0, held speed 0, reload 65535, forward.
`include "assert_macros.svh"

module stepper_slew_rate_period_gen (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic signed [ssrpg_pkg::SPEED_W-1:0] in_commanded_speed,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ssrpg_pkg::SPEED_W-1:0] out_slew_speed,
  output logic [ssrpg_pkg::RELOAD_W-1:0]     out_period_reload,
  output logic [ssrpg_pkg::CMP_W-1:0]        out_compare_value,
  output logic                               out_direction,
  output logic                               out_pulse_off,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssrpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssrpg_pkg::LIMIT_W-1:0]      cfg_data
);
  import ssrpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLAMP, ST_SLEW, ST_MAG, ST_DIV, ST_SAT, ST_DONE
  } state_t;

  state_t state_r;

  logic [LIMIT_W-1:0]        speed_limit_r;
  logic [LIMIT_W-1:0]        step_limit_r;
  logic signed [SPEED_W-1:0] cmd_r;
  logic signed [SPEED_W-1:0] target_r;
  logic signed [SPEED_W-1:0] held_r;
  logic [SPEED_W-1:0]        mag_r;
  logic [SPEED_W-1:0]        rem_r;
  logic [DIV_NUM_W-1:0]      quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [RELOAD_W-1:0]       reload_hold_r;
  logic                      dir_hold_r;
  logic                      stop_r;
  logic                      out_valid_r;

  // Clamp of the command to +/- speed limit
  logic signed [SPEED_W-1:0] lim_pos, lim_neg, target_nxt;
  always_comb begin
    lim_pos = $signed({1'b0, speed_limit_r});
    lim_neg = -lim_pos;
    priority if (cmd_r > lim_pos) target_nxt = lim_pos;
    else if (cmd_r < lim_neg)     target_nxt = lim_neg;
    else                          target_nxt = cmd_r;
  end

  // Slew step toward the target, limited to +/- step limit
  logic signed [SPEED_W:0]   diff, dlim_pos, dlim_neg, delta;
  logic signed [SPEED_W:0]   held_sum;
  logic signed [SPEED_W-1:0] held_nxt;
  always_comb begin
    diff     = $signed({target_r[SPEED_W-1], target_r})
               - $signed({held_r[SPEED_W-1], held_r});
    dlim_pos = $signed({2'b00, step_limit_r});
    dlim_neg = -dlim_pos;
    priority if (diff > dlim_pos) delta = dlim_pos;
    else if (diff < dlim_neg)     delta = dlim_neg;
    else                          delta = diff;
    held_sum = $signed({held_r[SPEED_W-1], held_r}) + delta;
    held_nxt = held_sum[SPEED_W-1:0];
  end

  // Magnitude of the held speed
  logic [SPEED_W-1:0] mag_nxt;
  always_comb begin
    mag_nxt = held_r[SPEED_W-1] ? SPEED_W'(-held_r) : SPEED_W'(held_r);
  end

  // Restoring divider step: one quotient bit per cycle
  logic [SPEED_W:0] rem_shift, trial;
  logic             trial_ok;
  always_comb begin
    rem_shift = {rem_r, DIV_NUM_BITS[cnt_r]};
    trial     = rem_shift - {1'b0, mag_r};
    trial_ok  = (rem_shift >= {1'b0, mag_r});
  end

  // Saturated reload from the quotient
  logic [RELOAD_W-1:0]  reload_nxt;
  logic [DIV_NUM_W-1:0] quo_m1;
  always_comb begin
    quo_m1 = quo_r - DIV_NUM_W'(1);
    priority if (quo_r < Q_LOW) reload_nxt = RELOAD_MIN;
    else if (quo_r > Q_HIGH)    reload_nxt = RELOAD_MAX;
    else                        reload_nxt = quo_m1[RELOAD_W-1:0];
  end

  // Result register loads once it is free or emptying this cycle
  logic res_load;
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // Sequencer, held state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      speed_limit_r <= '0;
      step_limit_r  <= '0;
      held_r        <= '0;
      reload_hold_r <= RELOAD_MAX;
      dir_hold_r    <= 1'b0;
      stop_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPEED_LIMIT: speed_limit_r <= cfg_data;
          CFG_STEP_LIMIT:  step_limit_r  <= cfg_data;
          default: ;
        endcase
      end

      priority if (res_load)          out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_commanded_speed;
            if (in_req_type == REQ_STOP) begin
              held_r  <= '0;
              stop_r  <= 1'b1;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_CLAMP;
            end
          end
        end
        ST_CLAMP: begin
          target_r <= target_nxt;
          state_r  <= ST_SLEW;
        end
        ST_SLEW: begin
          held_r  <= held_nxt;
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          mag_r <= mag_nxt;
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= CNT_W'(DIV_NUM_W - 1);
          if (mag_nxt < STOP_MAG) begin
            stop_r  <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            stop_r     <= 1'b0;
            dir_hold_r <= held_r[SPEED_W-1];
            state_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= trial_ok ? trial[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
          quo_r <= {quo_r[DIV_NUM_W-2:0], trial_ok};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) state_r <= ST_SAT;
        end
        ST_SAT: begin
          reload_hold_r <= reload_nxt;
          state_r       <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) begin
            out_slew_speed    <= held_r;
            out_period_reload <= reload_hold_r;
            out_compare_value <= stop_r ? '0 : reload_hold_r[RELOAD_W-1:1];
            out_direction     <= dir_hold_r;
            out_pulse_off     <= stop_r;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_stop_no_compare, out_valid && out_pulse_off, out_compare_value == '0)
  `ASSERT_SAME(a_run_reload, out_valid && !out_pulse_off,
               (out_period_reload >= RELOAD_MIN) &&
               (out_compare_value == out_period_reload[RELOAD_W-1:1]))
  `ASSERT_SAME(a_run_direction, out_valid && !out_pulse_off,
               out_direction == out_slew_speed[SPEED_W-1])

endmodule

[tb/tb_top.sv]
module tb_top;
  import ssrpg_pkg::*;

  // Run-wide constants
  localparam int WATCHDOG_TIME = 2_000_000;
  localparam int PHASE_ITEMS   = 225;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic signed [SPEED_W-1:0] slew_speed;
    logic [RELOAD_W-1:0]       period_reload;
    logic [CMP_W-1:0]          compare_value;
    logic                      direction;
    logic                      pulse_off;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic signed [SPEED_W-1:0] in_commanded_speed;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SPEED_W-1:0] out_slew_speed;
  logic [RELOAD_W-1:0] out_period_reload;
  logic [CMP_W-1:0] out_compare_value;
  logic out_direction;
  logic out_pulse_off;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0] cfg_data;

  // Slew model state and its register copies
  longint              held_speed;
  logic [RELOAD_W-1:0] reload_hold;
  logic                direction_hold;
  logic [LIMIT_W-1:0]  speed_limit;
  logic [LIMIT_W-1:0]  step_limit;

  timer_result_t pending_results[$];
  int fail_count;
  int burst_left;

  // Receiver pattern state
  logic [6:0] rx_phase = '0;
  logic [1:0] rx_mode = '0;

  stepper_slew_rate_period_gen u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_commanded_speed (in_commanded_speed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_slew_speed     (out_slew_speed),
    .out_period_reload  (out_period_reload),
    .out_compare_value  (out_compare_value),
    .out_direction      (out_direction),
    .out_pulse_off      (out_pulse_off),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  // Slew limiting and timer setting for one accepted transaction
  function automatic timer_result_t advance_slew(input logic req,
                                                 input logic signed [SPEED_W-1:0] cmd);
    timer_result_t r;
    longint target;
    longint delta;
    longint mag;
    longint quot;
    logic signed [SPEED_W-1:0] wrapped;
    r.pulse_off = 1'b1;
    r.compare_value = '0;
    if (req == REQ_STOP) begin
      held_speed = 0;
    end else begin
      target = longint'(cmd);
      if (target > longint'(speed_limit)) target = longint'(speed_limit);
      if (target < -longint'(speed_limit)) target = -longint'(speed_limit);
      delta = target - held_speed;
      if (delta > longint'(step_limit)) delta = longint'(step_limit);
      if (delta < -longint'(step_limit)) delta = -longint'(step_limit);
      wrapped = SPEED_W'(held_speed + delta);
      held_speed = longint'(wrapped);
      mag = (held_speed < 0) ? -held_speed : held_speed;
      // below 0.01 steps/s the pulses stop and the holds keep their values
      if (mag * 100 >= (longint'(1) << SPEED_FRAC_BITS)) begin
        direction_hold = (held_speed < 0);
        quot = DIV_NUM / mag;
        if (quot < longint'(RELOAD_MIN) + 1) reload_hold = RELOAD_MIN;
        else if (quot - 1 > longint'(RELOAD_MAX)) reload_hold = RELOAD_MAX;
        else reload_hold = RELOAD_W'(quot - 1);
        r.compare_value = CMP_W'(reload_hold >> 1);
        r.pulse_off = 1'b0;
      end
    end
    r.slew_speed = SPEED_W'(held_speed);
    r.period_reload = reload_hold;
    r.direction = direction_hold;
    return r;
  endfunction

  // Random target: wide values, the stop edge and both reload saturation edges
  function automatic logic signed [SPEED_W-1:0] pick_target();
    int m;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return SPEED_W'($urandom);
      3: m = $urandom_range(0, 8);
      4: m = 3890 + $urandom_range(0, 32);
      5: m = 51199992 + $urandom_range(0, 16);
      6: return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
      default: m = $urandom_range(0, 2 * int'(speed_limit) + 16);
    endcase
    return $urandom_range(0, 1) ? SPEED_W'(-m) : SPEED_W'(m);
  endfunction

  // One command transaction, then the sender's burst and gap pattern
  task automatic send_speed_cmd(input logic req, input logic signed [SPEED_W-1:0] cmd);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_commanded_speed <= cmd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_slew(req, cmd));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPEED_LIMIT) speed_limit = data;
    else if (idx == CFG_STEP_LIMIT) step_limit = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] lim, input logic [LIMIT_W-1:0] step);
    drain_results();
    write_reg(CFG_SPEED_LIMIT, lim);
    write_reg(CFG_STEP_LIMIT, step);
  endtask

  // Limits at reset are zero, so nothing moves
  task automatic test_reset_state();
    send_speed_cmd(REQ_STOP, SPEED_MAX);
    send_speed_cmd(REQ_TICK, SPEED_MAX);
  endtask

  task automatic test_full_scale();
    set_limits(LIMIT_MAX, LIMIT_MAX);
    send_speed_cmd(REQ_TICK, SPEED_MAX);
    send_speed_cmd(REQ_TICK, SPEED_MIN);
    send_speed_cmd(REQ_TICK, SPEED_MIN);
    send_speed_cmd(REQ_STOP, SPEED_MIN);
    send_speed_cmd(REQ_TICK, 0);
  endtask

  task automatic test_stop_threshold();
    send_speed_cmd(REQ_TICK, 2);
    send_speed_cmd(REQ_TICK, 3);
    send_speed_cmd(REQ_TICK, -3);
    send_speed_cmd(REQ_TICK, -2);
    send_speed_cmd(REQ_TICK, 1);
    send_speed_cmd(REQ_TICK, 0);
  endtask

  // Reload edges: 65535 at the slow end, 4 once the quotient drops under 5
  task automatic test_reload_saturation();
    send_speed_cmd(REQ_TICK, 3905);
    send_speed_cmd(REQ_TICK, 3906);
    send_speed_cmd(REQ_TICK, 3907);
    send_speed_cmd(REQ_TICK, 25600000);
    send_speed_cmd(REQ_TICK, 51200000);
    send_speed_cmd(REQ_TICK, 51200001);
    send_speed_cmd(REQ_TICK, -51200001);
  endtask

  task automatic test_zero_limits();
    set_limits(LIMIT_MAX, LIMIT_MAX);
    send_speed_cmd(REQ_TICK, 1000);
    set_limits(LIMIT_MAX, '0);
    send_speed_cmd(REQ_TICK, SPEED_MAX);
    send_speed_cmd(REQ_TICK, SPEED_MIN);
    set_limits('0, LIMIT_MAX);
    send_speed_cmd(REQ_TICK, 5000);
    set_limits(LIMIT_MAX, 26'd1000);
    send_speed_cmd(REQ_TICK, 5000);
  endtask

  // Writes past the last register must leave both limits alone
  task automatic test_spare_index();
    drain_results();
    write_reg(CFG_SPARE_A, LIMIT_W'($urandom));
    write_reg(CFG_SPARE_B, '0);
    send_speed_cmd(REQ_TICK, -7000);
  endtask

  // Ramps towards random targets under several limit settings
  task automatic test_random_phases();
    int ph;
    int n;
    int i;
    int run;
    logic signed [SPEED_W-1:0] tgt;
    logic [LIMIT_W-1:0] lim_set [0:5];
    logic [LIMIT_W-1:0] step_set [0:5];
    lim_set  = '{LIMIT_MAX, LIMIT_MAX, LIMIT_W'($urandom), 26'd51200001, 26'd4000,
                 LIMIT_W'($urandom)};
    step_set = '{LIMIT_MAX, LIMIT_W'($urandom_range(1, 1 << 20)), LIMIT_W'($urandom),
                 LIMIT_MAX, 26'd50, LIMIT_W'($urandom_range(0, 4096))};
    for (ph = 0; ph < 6; ph++) begin
      set_limits(lim_set[ph], step_set[ph]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_speed_cmd(REQ_STOP, SPEED_W'($urandom));
          n++;
        end else begin
          tgt = pick_target();
          run = $urandom_range(1, 16);
          for (i = 0; i < run; i++) send_speed_cmd(REQ_TICK, tgt);
          n += run;
        end
      end
    end
  endtask

  // Receiver stall pattern: a new mode each time the 7-bit phase counter wraps
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase == '0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_phase[1:0] != 2'd0);
      default: out_ready <= ~rx_phase[4];
    endcase
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_slew_speed !== want.slew_speed) begin
          $error("slew_speed: expected %0d, got %0d", want.slew_speed, out_slew_speed);
          fail_count++;
        end
        if (out_period_reload !== want.period_reload) begin
          $error("period_reload: expected %0d, got %0d", want.period_reload, out_period_reload);
          fail_count++;
        end
        if (out_compare_value !== want.compare_value) begin
          $error("compare_value: expected %0d, got %0d", want.compare_value, out_compare_value);
          fail_count++;
        end
        if (out_direction !== want.direction) begin
          $error("direction: expected %0b, got %0b", want.direction, out_direction);
          fail_count++;
        end
        if (out_pulse_off !== want.pulse_off) begin
          $error("pulse_off: expected %0b, got %0b", want.pulse_off, out_pulse_off);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_TIME);
    $display("Verification failed");
    $finish;
  end

  initial begin
    fail_count = 0;
    burst_left = 1;
    held_speed = 0;
    reload_hold = RELOAD_MAX;
    direction_hold = 1'b0;
    speed_limit = '0;
    step_limit = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_TICK;
    in_commanded_speed <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SPEED_LIMIT;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_full_scale();
    test_stop_threshold();
    test_reload_saturation();
    test_zero_limits();
    test_spare_index();
    test_random_phases();

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
